[src/epoch_seconds_date_converter_defines.svh]
// Assertion macros for the epoch seconds date converter RTL.
`ifndef EPOCH_SECONDS_DATE_CONVERTER_DEFINES_SVH
`define EPOCH_SECONDS_DATE_CONVERTER_DEFINES_SVH

// Checks cons in the same cycle as ante, outside reset.
`define ESDC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Checks cons in the cycle after ante, outside reset.
`define ESDC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/esdc_pkg.sv]
// Constants and stream payload types for the epoch seconds date converter.
package esdc_pkg;

  localparam int NSTG    = 11;
  localparam int TDATA_W = 72;

  localparam logic [21:0] JDN_L_OFS   = 22'd2509157;  // 68569 + Julian day of the epoch
  localparam logic [31:0] JDN_DAY_OFS = 32'd2472663;  // 32075 + Julian day of the epoch

  // Exact reciprocals: q = (x * M) >> S equals x / d for every x below 2^N,
  // with S = N + ceil(log2(d)) and M = ceil(2^S / d), which fits in N + 1 bits.
  localparam int DAY_S = 35;  // (seconds >> 7) / 675, N = 25
  localparam logic [25:0] DAY_M  = 26'(((64'd1 << DAY_S) + 64'd674) / 64'd675);
  localparam int CEN_S = 42;  // 4l / 146097, N = 24
  localparam logic [24:0] CEN_M  = 25'(((64'd1 << CEN_S) + 64'd146096) / 64'd146097);
  localparam int YR_S = 49;   // 4000(l + 1) / 1461001, N = 28
  localparam logic [28:0] YR_M   = 29'(((64'd1 << YR_S) + 64'd1461000) / 64'd1461001);
  localparam int MON_S = 28;  // 80l / 2447, N = 16
  localparam logic [16:0] MON_M  = 17'(((64'd1 << MON_S) + 64'd2446) / 64'd2447);
  localparam int DIV5_S = 16; // (2447m >> 4) / 5, N = 13
  localparam logic [13:0] DIV5_M = 14'(((64'd1 << DIV5_S) + 64'd4) / 64'd5);
  localparam int HR_S = 21;   // (rem >> 4) / 225, N = 13
  localparam logic [13:0] HR_M   = 14'(((64'd1 << HR_S) + 64'd224) / 64'd225);
  localparam int MIN_S = 14;  // (rem >> 2) / 15, N = 10
  localparam logic [10:0] MIN_M  = 11'(((64'd1 << MIN_S) + 64'd14) / 64'd15);
  localparam int DIV3_S = 13; // (367m >> 2) / 3, N = 11
  localparam logic [11:0] DIV3_M = 12'(((64'd1 << DIV3_S) + 64'd2) / 64'd3);
  localparam int C100_S = 20; // year / 100, N = 13
  localparam logic [13:0] C100_M = 14'(((64'd1 << C100_S) + 64'd99) / 64'd100);

  typedef struct packed {
    logic [5:0]  pad;
    logic [5:0]  second_in;
    logic [5:0]  minute_in;
    logic [4:0]  hour_in;
    logic [4:0]  day_in;
    logic [3:0]  month_in;
    logic [7:0]  year_in;
    logic [31:0] seconds_in;
  } in_fields_t;

  typedef struct packed {
    logic [5:0]  pad;
    logic [5:0]  second_out;
    logic [5:0]  minute_out;
    logic [4:0]  hour_out;
    logic [4:0]  day_out;
    logic [3:0]  month_out;
    logic [7:0]  year_out;
    logic [31:0] seconds_out;
  } out_fields_t;

endpackage

[src/epoch_seconds_date_converter.sv]
// Top level of the epoch seconds date converter, a pipelined Julian-day datapath.
//
//   channel  direction  handshake             payload
//   in_      slave      in_tvalid/in_tready   in_tdata fields, in_tuser mode
//   out_     master     out_tvalid/out_tready out_tdata fields
//
// Every item, in either mode, goes through 11 register stages, stage 0 to stage 10, and
// out_tvalid is the valid bit of the last stage.
// One item can enter in every cycle while the output is ready.
// The longest stage path is one reciprocal multiply of at most 28 by 29 bits.
// Reset clears only the stage valid bits; the data registers are left as they are.
// A stage holds its item while the stage behind it is full and blocked, and empty stages
// keep filling, so the input keeps taking transfers while a result waits at the output
// until every stage is full.
module epoch_seconds_date_converter (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  // seconds_in, year_in, month_in, day_in, hour_in, minute_in, second_in, zero pad
  input  logic [esdc_pkg::TDATA_W-1:0] in_tdata,
  // mode
  input  logic                         in_tuser,
  output logic                         out_tvalid,
  input  logic                         out_tready,
  // seconds_out, year_out, month_out, day_out, hour_out, minute_out, second_out, zero pad
  output logic [esdc_pkg::TDATA_W-1:0] out_tdata
);

  typedef struct packed {
    logic        mode;
    logic [31:0] secs;
    logic [50:0] dprod;
    logic [15:0] days;
    logic [16:0] rem;
    logic [21:0] l;
    logic [48:0] nprod;
    logic [6:0]  n;
    logic [15:0] l2;
    logic [26:0] hprod;
    logic [4:0]  hour;
    logic [11:0] rem2;
    logic [27:0] yx;
    logic [56:0] yprod;
    logic [20:0] mnprod;
    logic [6:0]  y;
    logic [8:0]  l3;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic [32:0] moprod;
    logic [4:0]  m;
    logic [16:0] dnum;
    logic [26:0] dvprod;
    logic [12:0] ya;
    logic [12:0] yc;
    logic [3:0]  mb;
    logic [4:0]  mday;
    logic [16:0] hms;
    logic [21:0] a;
    logic [12:0] bnum;
    logic [26:0] cprod;
    logic [22:0] bprod;
    logic [7:0]  c;
    logic [31:0] dsum;
    logic [31:0] tot;
    esdc_pkg::out_fields_t res;
  } pipe_t;

  logic [esdc_pkg::NSTG-1:0] vld_r;
  logic [esdc_pkg::NSTG-1:0] adv;
  pipe_t                     stg_r   [esdc_pkg::NSTG];
  pipe_t                     stg_nxt [esdc_pkg::NSTG];

  esdc_pkg::in_fields_t  in_f;
  esdc_pkg::out_fields_t out_res;
  logic                  early;
  logic [21:0]           l_sum;
  logic [6:0]            c_q;
  logic [6:0]            n_q;
  logic [4:0]            hour_q;
  logic [6:0]            y_q;
  logic [5:0]            minute_q;
  logic [15:0]           x80;
  logic [4:0]            m_q;
  logic [9:0]            dv_q;
  logic [1:0]            k;

  assign in_f       = in_tdata;
  assign in_tready  = adv[0];
  assign out_tvalid = vld_r[esdc_pkg::NSTG-1];
  assign out_res    = stg_r[esdc_pkg::NSTG-1].res;
  assign out_tdata  = out_res;

  // A stage may load when it is empty or when its own item moves on.
  always_comb begin
    adv[esdc_pkg::NSTG-1] = !vld_r[esdc_pkg::NSTG-1] || out_tready;
    for (int i = esdc_pkg::NSTG - 2; i >= 0; i--) begin
      adv[i] = !vld_r[i] || adv[i+1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (adv[0]) begin
        vld_r[0] <= in_tvalid;
      end
      for (int i = 1; i < esdc_pkg::NSTG; i++) begin
        if (adv[i]) begin
          vld_r[i] <= vld_r[i-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < esdc_pkg::NSTG; i++) begin
      if (adv[i]) begin
        stg_r[i] <= stg_nxt[i];
      end
    end
  end

  always_comb begin
    // Stage 0: day count reciprocal; calendar side prepares its year and month terms.
    // January and February count as months of the previous year.
    early            = in_f.month_in <= 4'd1;
    stg_nxt[0]       = '0;
    stg_nxt[0].mode  = in_tuser;
    stg_nxt[0].secs  = in_f.seconds_in;
    stg_nxt[0].dprod = 51'(in_f.seconds_in[31:7]) * 51'(esdc_pkg::DAY_M);
    stg_nxt[0].ya    = 13'(in_f.year_in) + (early ? 13'd6769 : 13'd6770);
    stg_nxt[0].yc    = 13'(in_f.year_in) + (early ? 13'd6869 : 13'd6870);
    stg_nxt[0].mb    = early ? in_f.month_in + 4'd11 : in_f.month_in - 4'd1;
    stg_nxt[0].mday  = in_f.day_in;
    stg_nxt[0].hms   = 17'(in_f.hour_in) * 17'd3600 + 17'(in_f.minute_in) * 17'd60
                     + 17'(in_f.second_in);

    // Stage 1
    stg_nxt[1]       = stg_r[0];
    stg_nxt[1].days  = stg_r[0].dprod[esdc_pkg::DAY_S +: 16];
    stg_nxt[1].a     = 22'((24'(stg_r[0].ya) * 24'd1461) >> 2);
    stg_nxt[1].bnum  = 13'(stg_r[0].mb) * 13'd367;
    stg_nxt[1].cprod = 27'(stg_r[0].yc) * 27'(esdc_pkg::C100_M);

    // Stage 2
    l_sum            = 22'(stg_r[1].days) + esdc_pkg::JDN_L_OFS;
    c_q              = stg_r[1].cprod[esdc_pkg::C100_S +: 7];
    stg_nxt[2]       = stg_r[1];
    stg_nxt[2].rem   = 17'(stg_r[1].secs - 32'(stg_r[1].days) * 32'd86400);
    stg_nxt[2].l     = l_sum;
    stg_nxt[2].nprod = 49'({l_sum, 2'b00}) * 49'(esdc_pkg::CEN_M);
    stg_nxt[2].bprod = 23'(stg_r[1].bnum[12:2]) * 23'(esdc_pkg::DIV3_M);
    stg_nxt[2].c     = 8'((9'(c_q) * 9'd3) >> 2);

    // Stage 3: n counts centuries and l2 is the day within the current century.
    n_q              = stg_r[2].nprod[esdc_pkg::CEN_S +: 7];
    stg_nxt[3]       = stg_r[2];
    stg_nxt[3].n     = n_q;
    stg_nxt[3].l2    = 16'(stg_r[2].l - 22'((24'(n_q) * 24'd146097 + 24'd3) >> 2));
    stg_nxt[3].hprod = 27'(stg_r[2].rem[16:4]) * 27'(esdc_pkg::HR_M);
    stg_nxt[3].dsum  = 32'(stg_r[2].mday) + 32'(stg_r[2].a)
                     + 32'(stg_r[2].bprod[esdc_pkg::DIV3_S +: 9])
                     - 32'(stg_r[2].c) - esdc_pkg::JDN_DAY_OFS;

    // Stage 4: the day count wraps modulo 2^32 together with the seconds total.
    hour_q           = stg_r[3].hprod[esdc_pkg::HR_S +: 5];
    stg_nxt[4]       = stg_r[3];
    stg_nxt[4].hour  = hour_q;
    stg_nxt[4].rem2  = 12'(stg_r[3].rem - 17'(hour_q) * 17'd3600);
    stg_nxt[4].yx    = (28'(stg_r[3].l2) + 28'd1) * 28'd4000;
    stg_nxt[4].tot   = stg_r[3].dsum * 32'd86400 + 32'(stg_r[3].hms);

    // Stage 5
    stg_nxt[5]        = stg_r[4];
    stg_nxt[5].yprod  = 57'(stg_r[4].yx) * 57'(esdc_pkg::YR_M);
    stg_nxt[5].mnprod = 21'(stg_r[4].rem2[11:2]) * 21'(esdc_pkg::MIN_M);

    // Stage 6: l3 counts days from the start of March, offset by 31.
    y_q               = stg_r[5].yprod[esdc_pkg::YR_S +: 7];
    minute_q          = stg_r[5].mnprod[esdc_pkg::MIN_S +: 6];
    stg_nxt[6]        = stg_r[5];
    stg_nxt[6].y      = y_q;
    stg_nxt[6].l3     = 9'(18'(stg_r[5].l2) - ((18'(y_q) * 18'd1461) >> 2) + 18'd31);
    stg_nxt[6].minute = minute_q;
    stg_nxt[6].second = 6'(stg_r[5].rem2 - 12'(minute_q) * 12'd60);

    // Stage 7
    x80               = 16'({stg_r[6].l3, 6'b000000}) + 16'({stg_r[6].l3, 4'b0000});
    stg_nxt[7]        = stg_r[6];
    stg_nxt[7].moprod = 33'(x80) * 33'(esdc_pkg::MON_M);

    // Stage 8
    m_q             = stg_r[7].moprod[esdc_pkg::MON_S +: 5];
    stg_nxt[8]      = stg_r[7];
    stg_nxt[8].m    = m_q;
    stg_nxt[8].dnum = 17'(m_q) * 17'd2447;

    // Stage 9
    stg_nxt[9]        = stg_r[8];
    stg_nxt[9].dvprod = 27'(stg_r[8].dnum[16:4]) * 27'(esdc_pkg::DIV5_M);

    // Stage 10: output register; k carries January and February into the next year.
    dv_q        = stg_r[9].dvprod[esdc_pkg::DIV5_S +: 10];
    k           = (stg_r[9].m >= 5'd22) ? 2'd2 : ((stg_r[9].m >= 5'd11) ? 2'd1 : 2'd0);
    stg_nxt[10] = stg_r[9];
    stg_nxt[10].res = '0;
    if (stg_r[9].mode) begin
      stg_nxt[10].res.seconds_out = stg_r[9].tot;
    end else begin
      stg_nxt[10].res.year_out   = 8'(16'(stg_r[9].n) * 16'd100 + 16'(stg_r[9].y)
                                 + 16'(k) - 16'd6870);
      stg_nxt[10].res.month_out  = 4'(5'(stg_r[9].m) + 5'd1 - 5'(k) * 5'd12);
      stg_nxt[10].res.day_out    = 5'(10'(stg_r[9].l3) - dv_q);
      stg_nxt[10].res.hour_out   = stg_r[9].hour;
      stg_nxt[10].res.minute_out = stg_r[9].minute;
      stg_nxt[10].res.second_out = stg_r[9].second;
    end
  end

`include "epoch_seconds_date_converter_defines.svh"

  `ESDC_ASSERT_NOW(a_empty_out_ready, !out_tvalid, in_tready,
                   "input blocked while the output stage is empty")
  `ESDC_ASSERT_NOW(a_unused_zero, out_tvalid,
                   out_tdata[31:0] == 32'd0 || out_tdata[65:32] == 34'd0,
                   "both result groups nonzero")
  `ESDC_ASSERT_NOW(a_time_range, out_tvalid,
                   out_res.hour_out <= 5'd23 && out_res.minute_out <= 6'd59
                   && out_res.second_out <= 6'd59 && out_res.month_out <= 4'd11,
                   "calendar field out of range")
  `ESDC_ASSERT_NEXT(a_stage_hold, vld_r[0] && !adv[0], vld_r[0],
                    "blocked first stage lost its item")

endmodule

[verif/tb_epoch_seconds_date_converter.sv]
// Self-checking testbench for the epoch seconds date converter, in both conversion directions.
module tb_epoch_seconds_date_converter;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic                 to_secs;
    esdc_pkg::in_fields_t f;
  } conv_req_t;

  logic                         clk = 1'b0;
  logic                         rst_n = 1'b0;
  logic                         in_tvalid = 1'b0;
  logic                         in_tready;
  // seconds_in, year_in, month_in, day_in, hour_in, minute_in, second_in, zero pad
  logic [esdc_pkg::TDATA_W-1:0] in_tdata = '0;
  // mode
  logic                         in_tuser = 1'b0;
  logic                         out_tvalid;
  logic                         out_tready = 1'b0;
  // seconds_out, year_out, month_out, day_out, hour_out, minute_out, second_out, zero pad
  logic [esdc_pkg::TDATA_W-1:0] out_tdata;

  conv_req_t            conv_requests[$];
  esdc_pkg::out_fields_t predicted_conversions[$];
  bit                   calm = 1'b0;
  int                   mismatches = 0;
  int                   split_count = 0;
  int                   join_count = 0;
  int                   results_checked = 0;

  epoch_seconds_date_converter i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Julian-day conversion in either direction; fields that a direction leaves unused stay zero.
  function automatic esdc_pkg::out_fields_t convert_time(logic to_secs,
                                                         esdc_pkg::in_fields_t f);
    esdc_pkg::out_fields_t r;
    longint unsigned jl, cen, yr, mon, dy, k, rem;
    longint mo, yy, adj, days;
    logic [63:0] total;
    r = '0;
    if (!to_secs) begin
      jl = 64'(f.seconds_in) / 86400 + 68569 + 2440588;
      cen = 4 * jl / 146097;
      jl = jl - (146097 * cen + 3) / 4;
      yr = 4000 * (jl + 1) / 1461001;
      jl = jl - 1461 * yr / 4 + 31;
      mon = 80 * jl / 2447;
      dy = jl - 2447 * mon / 80;
      k = mon / 11;
      mon = mon + 2 - 12 * k;
      yr = 100 * (cen - 49) + yr + k;
      rem = 64'(f.seconds_in) % 86400;
      r.year_out = 8'(yr - 1970);
      r.month_out = 4'(mon - 1);
      r.day_out = 5'(dy);
      r.hour_out = 5'(rem / 3600);
      r.minute_out = 6'(rem % 3600 / 60);
      r.second_out = 6'(rem % 60);
    end else begin
      mo = longint'(f.month_in) + 1;
      yy = longint'(f.year_in) + 1970;
      adj = (mo <= 2) ? -1 : 0;
      days = longint'(f.day_in) - 32075 - 2440588
           + 1461 * (yy + 4800 + adj) / 4
           + 367 * (mo - 2 - 12 * adj) / 12
           - 3 * ((yy + 4900 + adj) / 100) / 4;
      // A negative day count or a total past 2^32 wraps around.
      total = 64'(days[31:0]) * 86400 + 64'(f.hour_in) * 3600
            + 64'(f.minute_in) * 60 + 64'(f.second_in);
      r.seconds_out = total[31:0];
    end
    return r;
  endfunction

  function automatic conv_req_t make_req(logic to_secs, logic [31:0] secs, logic [7:0] yr,
                                         logic [3:0] mon, logic [4:0] dy, logic [4:0] hr,
                                         logic [5:0] mi, logic [5:0] se);
    conv_req_t q;
    q.to_secs = to_secs;
    q.f = '{pad: '0, second_in: se, minute_in: mi, hour_in: hr, day_in: dy,
            month_in: mon, year_in: yr, seconds_in: secs};
    return q;
  endfunction

  function automatic conv_req_t random_req();
    logic [31:0] secs;
    longint unsigned at_day;
    if ($urandom_range(0, 2) == 0) begin
      // Land on or next to a midnight to stress the day rollover.
      at_day = longint'($urandom_range(0, 49710)) * 86400;
      case ($urandom_range(0, 2))
        0: secs = 32'(at_day);
        1: secs = 32'(at_day + 86399);
        default: secs = 32'(at_day + $urandom_range(0, 3));
      endcase
    end else begin
      secs = $urandom;
    end
    if ($urandom_range(0, 1) == 0)
      return make_req(1'b0, secs, 8'($urandom), 4'($urandom), 5'($urandom), 5'($urandom),
                      6'($urandom), 6'($urandom));
    if ($urandom_range(0, 3) != 0)
      return make_req(1'b1, secs, 8'($urandom_range(0, 136)), 4'($urandom_range(0, 11)),
                      5'($urandom_range(1, 31)), 5'($urandom_range(0, 23)),
                      6'($urandom_range(0, 59)), 6'($urandom_range(0, 59)));
    return make_req(1'b1, secs, 8'($urandom), 4'($urandom), 5'($urandom), 5'($urandom),
                    6'($urandom), 6'($urandom));
  endfunction

  // Driver: keeps the front request on the bus until its transfer.
  always @(posedge clk) begin : drive_requests
    logic go;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        predicted_conversions.push_back(convert_time(in_tuser, in_tdata));
        if (in_tuser) join_count++;
        else split_count++;
        void'(conv_requests.pop_front());
      end
      if (!(in_tvalid && !in_tready)) begin
        go = (conv_requests.size() > 0) && (calm || $urandom_range(0, 99) >= 25);
        if (go) begin
          in_tdata <= conv_requests[0].f;
          in_tuser <= conv_requests[0].to_secs;
        end
        in_tvalid <= go;
      end
    end
  end

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= 10)
        $display("Mismatch on %s at %0t: expected %0d, got %0d", name, $realtime, want, got);
    end
  endtask

  // Monitor: every result transfer is compared with the oldest prediction.
  always @(posedge clk) begin : check_results
    esdc_pkg::out_fields_t want, got;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        got = out_tdata;
        if (predicted_conversions.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Result at %0t with no conversion outstanding: %h", $realtime, out_tdata);
        end else begin
          want = predicted_conversions.pop_front();
          results_checked++;
          check_field("seconds_out", want.seconds_out, got.seconds_out);
          check_field("year_out", want.year_out, got.year_out);
          check_field("month_out", want.month_out, got.month_out);
          check_field("day_out", want.day_out, got.day_out);
          check_field("hour_out", want.hour_out, got.hour_out);
          check_field("minute_out", want.minute_out, got.minute_out);
          check_field("second_out", want.second_out, got.second_out);
          check_field("pad", want.pad, got.pad);
        end
      end
      out_tready <= calm || ($urandom_range(0, 99) >= 25);
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: epoch edges, leap days, the 2^32 limit and unvalidated calendar fields.
    conv_requests.push_back(make_req(1'b0, 32'd0, '0, '0, '0, '0, '0, '0));
    conv_requests.push_back(make_req(1'b0, 32'hFFFF_FFFF, '1, '1, '1, '1, '1, '1));
    conv_requests.push_back(make_req(1'b0, 32'd86399, '0, '0, '0, '0, '0, '0));
    conv_requests.push_back(make_req(1'b0, 32'd86400, '0, '0, '0, '0, '0, '0));
    conv_requests.push_back(make_req(1'b0, 32'd68169600, '0, '0, '0, '0, '0, '0));
    conv_requests.push_back(make_req(1'b0, 32'd951782400, '0, '0, '0, '0, '0, '0));
    conv_requests.push_back(make_req(1'b0, 32'd951868799, '0, '0, '0, '0, '0, '0));
    conv_requests.push_back(make_req(1'b0, 32'h7FFF_FFFF, '0, '0, '0, '0, '0, '0));
    conv_requests.push_back(make_req(1'b0, 32'h8000_0000, '0, '0, '0, '0, '0, '0));
    conv_requests.push_back(make_req(1'b0, 32'd4107542399, '0, '0, '0, '0, '0, '0));
    conv_requests.push_back(make_req(1'b1, '1, 8'd0, 4'd0, 5'd1, 5'd0, 6'd0, 6'd0));
    // Day zero of the epoch month gives a negative day count.
    conv_requests.push_back(make_req(1'b1, '0, 8'd0, 4'd0, 5'd0, 5'd0, 6'd0, 6'd0));
    conv_requests.push_back(make_req(1'b1, '0, 8'd136, 4'd1, 5'd7, 5'd6, 6'd28, 6'd15));
    conv_requests.push_back(make_req(1'b1, '0, 8'd136, 4'd1, 5'd7, 5'd6, 6'd28, 6'd16));
    conv_requests.push_back(make_req(1'b1, '0, '1, '1, '1, '1, '1, '1));
    conv_requests.push_back(make_req(1'b1, '0, 8'd30, 4'd1, 5'd29, 5'd23, 6'd59, 6'd59));
    conv_requests.push_back(make_req(1'b1, '0, 8'd130, 4'd1, 5'd29, 5'd12, 6'd0, 6'd0));
    conv_requests.push_back(make_req(1'b1, '0, 8'd30, 4'd1, 5'd31, 5'd0, 6'd0, 6'd0));
    conv_requests.push_back(make_req(1'b1, '0, 8'd2, 4'd12, 5'd15, 5'd0, 6'd0, 6'd0));
    conv_requests.push_back(make_req(1'b1, '0, 8'd2, 4'd15, 5'd1, 5'd0, 6'd0, 6'd0));
    conv_requests.push_back(make_req(1'b1, '0, 8'd50, 4'd2, 5'd1, 5'd31, 6'd63, 6'd63));
    repeat (200) conv_requests.push_back(random_req());

    // Hold the sender back until the pipeline has fully drained.
    while (conv_requests.size() > 0 || predicted_conversions.size() > 0) @(negedge clk);

    repeat (200) conv_requests.push_back(random_req());
    calm = 1'b1;
    while (conv_requests.size() > 100) @(negedge clk);
    calm = 1'b0;

    while (conv_requests.size() > 0 || predicted_conversions.size() > 0) @(negedge clk);
    repeat (40) @(negedge clk);

    $display("Sent %0d seconds-to-date and %0d date-to-seconds transfers; %0d results compared.",
             split_count, join_count, results_checked);
    if (mismatches == 0 && predicted_conversions.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #400us;
    $display("Timed out with %0d results outstanding.", predicted_conversions.size());
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
